[design/assert_macros.svh]
// Assertion macros used by the hash map design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/oahm_pkg.sv]
// Types and constants of the open-addressed hash map.
`default_nettype none

package oahm_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_DEFINE   = 2'd1,
        OP_REDEFINE = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_PRESENT   = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MARK_UNUSED  = 2'd0,
        MARK_DELETED = 2'd1,
        MARK_ACTIVE  = 2'd2
    } mark_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value_in;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [VALUE_BITS-1:0] value_out;
        logic [CNT_BITS-1:0]   live_count;
    } rsp_t;

    typedef struct packed {
        mark_t                 mark;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic                  wr;
        logic [SLOT_BITS-1:0]  addr;
        entry_t                data;
        status_t               status;
        logic [VALUE_BITS-1:0] vout;
        logic                  inc;
        logic                  dec;
    } commit_t;

endpackage

`default_nettype wire

[design/oahm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module oahm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/open_address_hash_map.sv]
// A request is accepted, then probes its slots in order, then commits, and then the result is shown.
// A new request is taken only once the previous one has left the commit state; a probe visits at most SLOTS slots.
// The probe rate is set by the slot RAM, one read per cycle streamed ahead along the probe.
// Reset clears the per-slot valid bits, so every slot reads as unused at once; no clear pass.
// Reset also zeroes the live count and empties the result register.
// Key and value contents of a slot are undefined until that slot is first written.
`default_nettype none
`include "assert_macros.svh"

module open_address_hash_map
    import oahm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    state_t                state_reg, state_next;
    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_BITS-1:0]  home_reg;
    logic [SLOT_BITS-1:0]  cur_reg, cur_next;
    logic                  del_seen_reg, del_seen_next;
    logic [SLOT_BITS-1:0]  del_addr_reg, del_addr_next;
    logic                  vld_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [CNT_BITS-1:0]   total_reg, total_next;
    commit_t               cmt_reg, cmt_next;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  accept;
    logic                  rsp_free;
    logic                  stop;
    logic                  ram_rd_en;
    logic [SLOT_BITS-1:0]  ram_rd_addr;
    logic [ENTRY_BITS-1:0] ram_rd_data;
    logic                  ram_wr_en;
    entry_t                rd_entry;
    logic [SLOT_BITS-1:0]  stride;
    logic                  last;
    logic                  is_active;
    logic                  is_deleted;
    logic                  is_unused;
    logic                  is_match;
    logic                  rsp_load;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign rd_entry   = entry_t'(ram_rd_data);
    assign stride     = home_reg | SLOT_BITS'(1);
    assign is_active  = vld_reg && (rd_entry.mark == MARK_ACTIVE);
    assign is_deleted = vld_reg && (rd_entry.mark == MARK_DELETED);
    assign is_unused  = !is_active && !is_deleted;
    assign is_match   = is_active && (rd_entry.key == key_reg);
    assign cur_next   = cur_reg + stride;
    assign last       = (cur_next == home_reg);

    oahm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cmt_reg.addr),
        .wr_data (cmt_reg.data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stop)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        logic                 del_seen_now;
        logic [SLOT_BITS-1:0] del_addr_now;

        ram_rd_en     = 1'b0;
        ram_rd_addr   = cur_next;
        ram_wr_en     = 1'b0;
        rsp_load      = 1'b0;
        stop          = 1'b0;
        del_seen_next = del_seen_reg;
        del_addr_next = del_addr_reg;
        del_seen_now  = del_seen_reg || is_deleted;
        del_addr_now  = del_seen_reg ? del_addr_reg : cur_reg;

        cmt_next        = cmt_reg;
        cmt_next.wr     = 1'b0;
        cmt_next.addr   = cur_reg;
        cmt_next.data   = rd_entry;
        cmt_next.status = STAT_OK;
        cmt_next.vout   = '0;
        cmt_next.inc    = 1'b0;
        cmt_next.dec    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = req.key[SLOT_BITS-1:0];
                ram_rd_en   = req_valid;
            end
            S_PROBE:
            begin
                ram_rd_en = 1'b1;
                if (is_match)
                begin
                    stop = 1'b1;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            cmt_next.vout = rd_entry.value;
                        end
                        OP_DEFINE:
                        begin
                            cmt_next.status = STAT_PRESENT;
                        end
                        OP_REDEFINE:
                        begin
                            cmt_next.wr         = 1'b1;
                            cmt_next.data.value = val_reg;
                        end
                        default:
                        begin
                            cmt_next.wr        = 1'b1;
                            cmt_next.data.mark = MARK_DELETED;
                            cmt_next.dec       = 1'b1;
                        end
                    endcase
                end
                else if (is_unused)
                begin
                    stop = 1'b1;
                    if (op_reg == OP_DEFINE)
                    begin
                        cmt_next.wr         = 1'b1;
                        cmt_next.data.mark  = MARK_ACTIVE;
                        cmt_next.data.key   = key_reg;
                        cmt_next.data.value = val_reg;
                        cmt_next.inc        = 1'b1;
                    end
                    else
                    begin
                        cmt_next.status = STAT_NOT_FOUND;
                    end
                end
                else
                begin
                    del_seen_next = del_seen_now;
                    del_addr_next = del_addr_now;
                    if (last)
                    begin
                        stop = 1'b1;
                        if (op_reg != OP_DEFINE)
                        begin
                            cmt_next.status = STAT_NOT_FOUND;
                        end
                        else if (del_seen_now)
                        begin
                            cmt_next.wr         = 1'b1;
                            cmt_next.addr       = del_addr_now;
                            cmt_next.data.mark  = MARK_ACTIVE;
                            cmt_next.data.key   = key_reg;
                            cmt_next.data.value = val_reg;
                            cmt_next.inc        = 1'b1;
                        end
                        else
                        begin
                            cmt_next.status = STAT_FULL;
                        end
                    end
                end
            end
            S_COMMIT:
            begin
                if (rsp_free)
                begin
                    ram_wr_en = cmt_reg.wr;
                    rsp_load  = 1'b1;
                end
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    assign total_next = total_reg + CNT_BITS'(cmt_reg.inc) - CNT_BITS'(cmt_reg.dec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            total_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            del_seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                del_seen_reg <= 1'b0;
            end
            else if (state_reg == S_PROBE)
            begin
                del_seen_reg <= del_seen_next;
            end
            if (ram_wr_en)
            begin
                valid_reg[cmt_reg.addr] <= 1'b1;
            end
            if (rsp_load)
            begin
                total_reg     <= total_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_rd_en)
        begin
            vld_reg <= valid_reg[ram_rd_addr];
        end
        if (accept)
        begin
            op_reg   <= req.op;
            key_reg  <= req.key;
            val_reg  <= req.value_in;
            home_reg <= req.key[SLOT_BITS-1:0];
            cur_reg  <= req.key[SLOT_BITS-1:0];
        end
        else if (state_reg == S_PROBE)
        begin
            cur_reg      <= cur_next;
            del_addr_reg <= del_addr_next;
            cmt_reg      <= cmt_next;
        end
        if (rsp_load)
        begin
            rsp_reg.status     <= cmt_reg.status;
            rsp_reg.value_out  <= cmt_reg.vout;
            rsp_reg.live_count <= total_next;
        end
    end

    `ASSERT_NEXT(a_accept_probe, clk, rst_n, accept, state_reg == S_PROBE, "accepted beat did not start a probe")
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, total_reg <= CNT_BITS'(SLOTS), "live count exceeds the slot count")
    `ASSERT_IMPL(a_rsp_from_commit, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == S_COMMIT, "result beat without a commit")
    `ASSERT_NEXT(a_commit_holds, clk, rst_n, state_reg == S_COMMIT && rsp_valid_reg && rsp_stall, state_reg == S_COMMIT && $stable(rsp_reg), "commit overran a stalled result beat")

endmodule

`default_nettype wire
